// ===== design/hcaa_pkg.sv =====
// ----------------------------------------------------------------------------
// hcaa_pkg: shared definitions of the core affinity allocator
// Widths, full-scale constants, score thresholds and the classified item type.
// ----------------------------------------------------------------------------
package hcaa_pkg;

  // Q16 fixed point: 1.0 is 65536, normalized metrics need 17 bits
  localparam int N_W   = 17;
  localparam logic [N_W-1:0] Q_ONE = 17'h10000;

  // Scores reach at most ten times 1.0
  localparam int SCORE_W = 20;
  localparam int COUNT_W = 3;

  localparam int NUM_METRICS = 5;
  localparam int METRIC_W    = 32;

  // Full scale of each metric, in input order
  localparam longint unsigned FULL_SCALE [NUM_METRICS] =
    '{64'd108, 64'd12784, 64'd2515517, 64'd661065, 64'd1007};

  // Metric slots
  localparam int M_ENERGY = 0;
  localparam int M_PHASE  = 1;
  localparam int M_L1     = 2;
  localparam int M_L2     = 3;
  localparam int M_SHARE  = 4;

  // Size score above this picks the big pool first
  localparam logic [SCORE_W-1:0] SIZE_THRESHOLD = 20'd327680;
  // One core of allowance per this much of A * MAX_PER_TASK
  localparam longint unsigned ALLOW_STEP = 64'd655360;

  localparam int MAX_PER_TASK_DEFAULT = 4;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Result of classification, handed from front to back
  typedef struct packed {
    logic               prefers_big;
    logic [COUNT_W-1:0] core_count;
  } hcaa_class_t;

endpackage

// ===== design/hcaa_if.sv =====
// ----------------------------------------------------------------------------
// hcaa_if: channel interfaces of the core affinity allocator
// Metric channel into the block and affinity channel out of it.
// ----------------------------------------------------------------------------

// Task metrics, one transaction per task
interface hcaa_metrics_if;
  logic        valid;
  logic        ready;
  logic [31:0] energy_metric;
  logic [31:0] phase_metric;
  logic [31:0] first_level_misses;
  logic [31:0] second_level_misses;
  logic [31:0] sharing_metric;

  modport source (
    output valid, energy_metric, phase_metric, first_level_misses,
           second_level_misses, sharing_metric,
    input  ready
  );
  modport sink (
    input  valid, energy_metric, phase_metric, first_level_misses,
           second_level_misses, sharing_metric,
    output ready
  );
endinterface

// Affinity decision, one transaction per task
interface hcaa_affinity_if;
  logic       valid;
  logic       ready;
  logic [3:0] core_mask;
  logic [2:0] core_count;
  logic       prefers_big;

  modport source (
    output valid, core_mask, core_count, prefers_big,
    input  ready
  );
  modport sink (
    input  valid, core_mask, core_count, prefers_big,
    output ready
  );
endinterface

// ===== design/hcaa_front.sv =====
// ----------------------------------------------------------------------------
// hcaa_front: metric normalization and task classification
// Three-stage pipeline: reciprocal multiply, remainder correction, scoring.
// ----------------------------------------------------------------------------
module hcaa_front #(
  parameter int MAX_PER_TASK = hcaa_pkg::MAX_PER_TASK_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  hcaa_metrics_if.sink          metrics,
  output logic                  push_valid,
  input  logic                  push_ready,
  output hcaa_pkg::hcaa_class_t push_item
);

  localparam int NW = hcaa_pkg::N_W;
  localparam int SW = hcaa_pkg::SCORE_W;
  localparam int CW = hcaa_pkg::COUNT_W;
  localparam int NM = hcaa_pkg::NUM_METRICS;
  localparam int VW = SW + 3;

  // Stage enables, back to front
  logic v1, v2, v3;
  logic en1, en2, en3;

  assign en3 = !v3 || push_ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign metrics.ready = en1;

  logic [31:0] x [NM];
  assign x[hcaa_pkg::M_ENERGY] = metrics.energy_metric;
  assign x[hcaa_pkg::M_PHASE]  = metrics.phase_metric;
  assign x[hcaa_pkg::M_L1]     = metrics.first_level_misses;
  assign x[hcaa_pkg::M_L2]     = metrics.second_level_misses;
  assign x[hcaa_pkg::M_SHARE]  = metrics.sharing_metric;

  logic [NW-1:0] n [NM];

  // Per-metric normalization: q0 = x*R >> s is floor or one short,
  // a remainder check fixes it; at or above full scale it saturates
  for (genvar i = 0; i < NM; i++) begin : g_norm
    localparam longint unsigned D  = hcaa_pkg::FULL_SCALE[i];
    localparam int              S  = $clog2(D + 1);
    localparam longint unsigned R  = (64'd1 << (16 + S)) / D;
    localparam int              RW = $clog2(R + 1);
    localparam int              PW = S + NW;

    logic [S+RW-1:0] prod;
    logic [NW-1:0]   q0;
    logic [S-1:0]    xs;
    logic            sat;
    logic [PW-1:0]   scaled;
    logic [PW-1:0]   qd;
    logic [PW-1:0]   rem;

    assign prod = (S+RW)'(x[i][S-1:0]) * (S+RW)'(R);

    // Stage 1: estimate quotient
    always_ff @(posedge clk) begin
      if (en1) begin
        q0  <= prod[S+NW-1:S];
        xs  <= x[i][S-1:0];
        sat <= (64'(x[i]) >= D);
      end
    end

    assign scaled = PW'({xs, 16'h0000});
    assign qd     = PW'(q0) * PW'(D);
    assign rem    = scaled - qd;

    // Stage 2: correct and saturate
    always_ff @(posedge clk) begin
      if (en2) begin
        if (sat) begin
          n[i] <= hcaa_pkg::Q_ONE;
        end else if (rem >= PW'(D)) begin
          n[i] <= NW'(q0 + NW'(1));
        end else begin
          n[i] <= q0;
        end
      end
    end
  end

  // Scores and core count
  logic [NW-1:0] inv_e;
  logic [SW-1:0] size_score;
  logic [SW-1:0] allow_score;
  logic [VW-1:0] allow_scaled;
  logic [CW-1:0] count;

  always_comb begin
    inv_e = NW'(hcaa_pkg::Q_ONE - n[hcaa_pkg::M_ENERGY]);
    size_score = SW'(SW'(inv_e) * SW'(3)) + SW'(SW'(n[hcaa_pkg::M_PHASE]) * SW'(3))
               + SW'(SW'(n[hcaa_pkg::M_L1]) * SW'(2)) + SW'(SW'(n[hcaa_pkg::M_L2]) * SW'(2));
    allow_score = SW'(SW'(inv_e) * SW'(2)) + SW'(SW'(n[hcaa_pkg::M_PHASE]) * SW'(4))
                + SW'(SW'(n[hcaa_pkg::M_SHARE]) * SW'(4));
    allow_scaled = VW'(allow_score) * VW'(MAX_PER_TASK);
    // ceil(v / step) is the number of multiples of step lying below v
    count = '0;
    for (int k = 0; k < MAX_PER_TASK; k++) begin
      if (allow_scaled > VW'(VW'(k) * VW'(hcaa_pkg::ALLOW_STEP))) begin
        count = CW'(count + CW'(1));
      end
    end
  end

  // Stage 3: classified item
  always_ff @(posedge clk) begin
    if (en3) begin
      push_item.prefers_big <= (size_score > hcaa_pkg::SIZE_THRESHOLD);
      push_item.core_count  <= count;
    end
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= metrics.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  assign push_valid = v3;

endmodule

// ===== design/hcaa_queue.sv =====
// ----------------------------------------------------------------------------
// hcaa_queue: short queue of classified items
// Decouples the classifier pipeline from the core picker.
// ----------------------------------------------------------------------------
module hcaa_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  hcaa_pkg::hcaa_class_t push_item,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output hcaa_pkg::hcaa_class_t pop_item
);

  localparam int DEPTH = hcaa_pkg::QUEUE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW    = $clog2(DEPTH + 1);

  hcaa_pkg::hcaa_class_t entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [LW-1:0] fill;
  logic          push;
  logic          pop;

  assign push_ready = (fill != LW'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = entries[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_item;
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : AW'(wr_ptr + AW'(1));
      if (pop)  rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : AW'(rd_ptr + AW'(1));
      if (push && !pop)      fill <= LW'(fill + LW'(1));
      else if (pop && !push) fill <= LW'(fill - LW'(1));
    end
  end

  // Fill level rises on a lone push and stays within the depth
  a_fill_inc: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (fill == LW'($past(fill) + LW'(1))))
    else $error("queue fill did not rise on a lone push");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (fill <= LW'(DEPTH)))
    else $error("queue fill beyond depth");

endmodule

// ===== design/hcaa_back.sv =====
// ----------------------------------------------------------------------------
// hcaa_back: round-robin core picker and result register
// Spreads the core count over the preferred and the other pool.
// ----------------------------------------------------------------------------
module hcaa_back #(
  parameter int MAX_PER_TASK = hcaa_pkg::MAX_PER_TASK_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  pop_valid,
  output logic                  pop_ready,
  input  hcaa_pkg::hcaa_class_t pop_item,
  hcaa_affinity_if.source       affinity
);

  localparam int CW = hcaa_pkg::COUNT_W;

  logic big_ptr;
  logic little_ptr;
  logic pop;

  logic [1:0]    pref_k;
  logic [1:0]    other_k;
  logic [1:0]    big_k;
  logic [1:0]    little_k;
  logic [1:0]    big_bits;
  logic [1:0]    little_bits;

  // Picks from one pool of two cores
  function automatic logic [1:0] pool_bits(input logic [1:0] k, input logic ptr);
    logic [1:0] bits;
    case (k)
      2'd1:    bits = ptr ? 2'b10 : 2'b01;
      2'd2:    bits = 2'b11;
      default: bits = 2'b00;
    endcase
    return bits;
  endfunction

  assign pop_ready = !affinity.valid || affinity.ready;
  assign pop       = pop_valid && pop_ready;

  // Split count: first two from the preferred pool
  always_comb begin
    pref_k   = (pop_item.core_count >= CW'(2)) ? 2'd2 : pop_item.core_count[1:0];
    other_k  = 2'(pop_item.core_count - CW'(pref_k));
    big_k    = pop_item.prefers_big ? pref_k : other_k;
    little_k = pop_item.prefers_big ? other_k : pref_k;
    big_bits    = pool_bits(big_k, big_ptr);
    little_bits = pool_bits(little_k, little_ptr);
  end

  // Round-robin pointers: an odd number of picks toggles
  always_ff @(posedge clk) begin
    if (rst) begin
      big_ptr    <= 1'b0;
      little_ptr <= 1'b0;
    end else if (pop) begin
      big_ptr    <= big_ptr ^ big_k[0];
      little_ptr <= little_ptr ^ little_k[0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (pop) begin
      affinity.core_mask   <= {little_bits, big_bits};
      affinity.core_count  <= pop_item.core_count;
      affinity.prefers_big <= pop_item.prefers_big;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      affinity.valid <= 1'b0;
    end else if (pop) begin
      affinity.valid <= 1'b1;
    end else if (affinity.ready) begin
      affinity.valid <= 1'b0;
    end
  end

  // Mask agrees with the count it was built from
  a_mask_count: assert property (@(posedge clk) disable iff (rst)
    affinity.valid |-> ($countones(affinity.core_mask) == int'(affinity.core_count)))
    else $error("core mask population differs from core count");

  a_ptr_hold: assert property (@(posedge clk) disable iff (rst)
    !pop |=> ($stable(big_ptr) && $stable(little_ptr)))
    else $error("pool pointer moved without a transaction");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    pop |-> (pop_item.core_count <= CW'(MAX_PER_TASK)))
    else $error("core count above per-task limit");

endmodule

// ===== design/hetero_core_affinity_allocator_core.sv =====
// ----------------------------------------------------------------------------
// hetero_core_affinity_allocator_core: task to core affinity allocator
// Top level: classifier front end, queue and round-robin core picker.
// ----------------------------------------------------------------------------
// Each task's five metrics are normalized to Q16 against fixed full scales,
// scored, and turned into a 4-bit affinity mask over two big cores (0, 1)
// and two little cores (2, 3). One task is accepted and one result is
// delivered per clock cycle when the output side keeps taking results; the
// normalization and scoring are pipelined over three front stages, and the
// only state carried from task to task is the pair of one-bit pool pointers
// in the picker, updated in the cycle a task leaves the queue. A four-entry
// queue lets the front end keep accepting while a result waits at the output.
module hetero_core_affinity_allocator_core #(
  parameter int MAX_PER_TASK = hcaa_pkg::MAX_PER_TASK_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  hcaa_metrics_if.sink    metrics,
  hcaa_affinity_if.source affinity
);

  logic                  push_valid;
  logic                  push_ready;
  hcaa_pkg::hcaa_class_t push_item;
  logic                  pop_valid;
  logic                  pop_ready;
  hcaa_pkg::hcaa_class_t pop_item;

  hcaa_front #(
    .MAX_PER_TASK (MAX_PER_TASK)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .metrics    (metrics),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  hcaa_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  hcaa_back #(
    .MAX_PER_TASK (MAX_PER_TASK)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .affinity  (affinity)
  );

endmodule

// ===== tb/sv/hcaa_affinity_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hcaa_affinity_checker: in-order scoreboard for the core affinity allocator
// Watches the metric and affinity channels. Each accepted task is scored from
// its metrics and the two pool pointers, and the predicted mask, count and
// pool preference are queued. Each accepted result is compared field by
// field with the oldest queued prediction.
// ----------------------------------------------------------------------------
module hcaa_affinity_checker #(
  parameter int MAX_PER_TASK = hcaa_pkg::MAX_PER_TASK_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  hcaa_metrics_if     metrics,
  hcaa_affinity_if    affinity,
  output int unsigned tasks_in_flight,
  output int unsigned mismatch_count
);

  typedef struct packed {
    logic [3:0] core_mask;
    logic [2:0] core_count;
    logic       prefers_big;
  } affinity_t;

  // Q16 unity, pool threshold and the allowance step per core
  localparam longint unsigned Q16_ONE       = 64'd65536;
  localparam longint unsigned BIG_THRESHOLD = 64'd327680;
  localparam longint unsigned CORE_STEP     = 64'd655360;

  // Full scale of each metric
  localparam longint unsigned FS_ENERGY = 64'd108;
  localparam longint unsigned FS_PHASE  = 64'd12784;
  localparam longint unsigned FS_L1     = 64'd2515517;
  localparam longint unsigned FS_L2     = 64'd661065;
  localparam longint unsigned FS_SHARE  = 64'd1007;

  // Only the first few mismatches are printed, all are counted
  localparam int unsigned PRINT_CAP = 30;

  affinity_t expected_affinity [$];
  logic      big_ptr;
  logic      little_ptr;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) begin
      $display("%0t ns: MISMATCH: %s", $time, msg);
    end
  endtask

  // floor(x * 65536 / full scale), saturated at 1.0
  function automatic longint unsigned scale_to_q16(input logic [31:0] x,
                                                   input longint unsigned fs);
    longint unsigned q;
    q = {16'd0, x, 16'd0};
    q = q / fs;
    return (q > Q16_ONE) ? Q16_ONE : q;
  endfunction

  // Next core of a pool; the pool's pointer moves on every pick
  function automatic logic [1:0] take_core(input logic from_big);
    logic [1:0] core;
    if (from_big) begin
      core    = {1'b0, big_ptr};
      big_ptr = ~big_ptr;
    end else begin
      core       = {1'b1, little_ptr};
      little_ptr = ~little_ptr;
    end
    return core;
  endfunction

  // Affinity of one task; advances the pool pointers
  function automatic affinity_t predict_affinity(input logic [31:0] energy,
                                                 input logic [31:0] phase,
                                                 input logic [31:0] l1_miss,
                                                 input logic [31:0] l2_miss,
                                                 input logic [31:0] sharing);
    longint unsigned inv_energy, n_phase, n_l1, n_l2, n_share;
    longint unsigned size_score, allow_score, cores;
    affinity_t       res;
    logic            from_big;
    inv_energy  = Q16_ONE - scale_to_q16(energy, FS_ENERGY);
    n_phase     = scale_to_q16(phase, FS_PHASE);
    n_l1        = scale_to_q16(l1_miss, FS_L1);
    n_l2        = scale_to_q16(l2_miss, FS_L2);
    n_share     = scale_to_q16(sharing, FS_SHARE);
    size_score  = 3 * inv_energy + 3 * n_phase + 2 * n_l1 + 2 * n_l2;
    allow_score = 2 * inv_energy + 4 * n_phase + 4 * n_share;
    cores = (allow_score * longint'(MAX_PER_TASK) + CORE_STEP - 1) / CORE_STEP;
    if (cores > longint'(MAX_PER_TASK)) begin
      cores = longint'(MAX_PER_TASK);
    end
    // a score sitting exactly on the threshold stays with the little pool
    res.prefers_big = (size_score > BIG_THRESHOLD);
    res.core_count  = cores[2:0];
    res.core_mask   = 4'd0;
    // two picks from the preferred pool, the rest from the other one
    for (int i = 0; i < int'(cores); i++) begin
      from_big = (i < 2) ? res.prefers_big : ~res.prefers_big;
      res.core_mask[take_core(from_big)] = 1'b1;
    end
    return res;
  endfunction

  // Results are checked before the task of the same edge is queued
  always @(posedge clk) begin
    affinity_t got;
    affinity_t want;
    affinity_t pred;
    if (rst) begin
      big_ptr    = 1'b0;
      little_ptr = 1'b0;
      expected_affinity.delete();
    end else begin
      if (affinity.valid && affinity.ready) begin
        got = '{affinity.core_mask, affinity.core_count, affinity.prefers_big};
        if (expected_affinity.size() == 0) begin
          report_mismatch($sformatf("unexpected result mask %h count %0d big %b",
                                    got.core_mask, got.core_count,
                                    got.prefers_big));
        end else begin
          want = expected_affinity.pop_front();
          if (got.core_mask !== want.core_mask) begin
            report_mismatch($sformatf("core_mask got %h expected %h",
                                      got.core_mask, want.core_mask));
          end
          if (got.core_count !== want.core_count) begin
            report_mismatch($sformatf("core_count got %0d expected %0d",
                                      got.core_count, want.core_count));
          end
          if (got.prefers_big !== want.prefers_big) begin
            report_mismatch($sformatf("prefers_big got %b expected %b",
                                      got.prefers_big, want.prefers_big));
          end
        end
      end
      if (metrics.valid && metrics.ready) begin
        pred = predict_affinity(metrics.energy_metric,
                                metrics.phase_metric,
                                metrics.first_level_misses,
                                metrics.second_level_misses,
                                metrics.sharing_metric);
        expected_affinity.insert(expected_affinity.size(), pred);
      end
    end
    tasks_in_flight <= expected_affinity.size();
  end

endmodule

// ===== tb/sv/hetero_core_affinity_allocator_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hetero_core_affinity_allocator_core_tb: testbench of the affinity allocator
// Drives task metrics with random gaps and stalls the result channel at
// random. A directed set covers zero, full and saturated metrics, zero
// allowance and the pool threshold; random tasks follow, mostly in range with
// some idle tasks, threshold tasks and raw 32-bit values. Checking is done by
// hcaa_affinity_checker; this module only stimulates and gives the verdict.
// ----------------------------------------------------------------------------
module hetero_core_affinity_allocator_core_tb;

  localparam int          MAX_CORES     = hcaa_pkg::MAX_PER_TASK_DEFAULT;
  localparam int unsigned RANDOM_TASKS  = 1650;
  localparam int unsigned STRETCH_TASKS = 150;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  localparam int unsigned FS_ENERGY = 108;
  localparam int unsigned FS_PHASE  = 12784;
  localparam int unsigned FS_L1     = 2515517;
  localparam int unsigned FS_L2     = 661065;
  localparam int unsigned FS_SHARE  = 1007;

  logic        clk;
  logic        rst;
  int unsigned cycle_count;
  int unsigned tasks_in_flight;
  int unsigned mismatch_count;

  hcaa_metrics_if  metrics_ch ();
  hcaa_affinity_if affinity_ch ();

  hetero_core_affinity_allocator_core #(
    .MAX_PER_TASK (MAX_CORES)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .metrics  (metrics_ch),
    .affinity (affinity_ch)
  );

  hcaa_affinity_checker #(
    .MAX_PER_TASK (MAX_CORES)
  ) scoreboard (
    .clk             (clk),
    .rst             (rst),
    .metrics         (metrics_ch),
    .affinity        (affinity_ch),
    .tasks_in_flight (tasks_in_flight),
    .mismatch_count  (mismatch_count)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(6, 24);
  endfunction

  // One metric: in range mostly, with edges, saturation and raw words
  function automatic logic [31:0] metric_value(input int unsigned fs);
    logic [31:0] v;
    case ($urandom_range(0, 15))
      0:       v = 32'd0;
      1:       v = 32'hFFFF_FFFF;
      2, 3:    v = $urandom();
      4:       v = fs - 1 + $urandom_range(0, 2);
      5:       v = $urandom_range(0, fs / 64);
      default: v = $urandom_range(0, fs);
    endcase
    return v;
  endfunction

  // One task transaction; valid stays high on return
  task automatic send_metrics(input logic [31:0] energy, input logic [31:0] phase,
                              input logic [31:0] l1_miss, input logic [31:0] l2_miss,
                              input logic [31:0] sharing);
    @(negedge clk);
    metrics_ch.valid               <= 1'b1;
    metrics_ch.energy_metric       <= energy;
    metrics_ch.phase_metric        <= phase;
    metrics_ch.first_level_misses  <= l1_miss;
    metrics_ch.second_level_misses <= l2_miss;
    metrics_ch.sharing_metric      <= sharing;
    do @(posedge clk); while (metrics_ch.ready !== 1'b1);
  endtask

  // Gap with valid low after a transaction; n sets its length
  task automatic sender_gap(input int unsigned n);
    if (n > 0) begin
      @(negedge clk);
      metrics_ch.valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Hold off until every queued result has come out
  task automatic drain_results();
    @(negedge clk);
    metrics_ch.valid <= 1'b0;
    while (tasks_in_flight != 0) @(negedge clk);
  endtask

  // Result side: bursts of ready, long ones at times, and random stalls
  initial begin
    int unsigned n;
    affinity_ch.ready = 1'b0;
    forever begin
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 200)
                                       : $urandom_range(1, 6);
      repeat (n) begin
        @(negedge clk);
        affinity_ch.ready <= 1'b1;
      end
      n = idle_len();
      repeat (n) begin
        @(negedge clk);
        affinity_ch.ready <= 1'b0;
      end
    end
  end

  // Stimulus and verdict
  initial begin
    logic        gaps_on;
    logic [31:0] e, p, l1, l2, s;
    cycle_count                    = 0;
    rst                            = 1'b1;
    metrics_ch.valid               = 1'b0;
    metrics_ch.energy_metric       = 32'd0;
    metrics_ch.phase_metric        = 32'd0;
    metrics_ch.first_level_misses  = 32'd0;
    metrics_ch.second_level_misses = 32'd0;
    metrics_ch.sharing_metric      = 32'd0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // all zero, all ones
    send_metrics(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);                sender_gap(idle_len());
    send_metrics('1, '1, '1, '1, '1);                               sender_gap(idle_len());
    // zero allowance, little and largest size score
    send_metrics(FS_ENERGY, 32'd0, 32'd0, 32'd0, 32'd0);            sender_gap(idle_len());
    send_metrics('1, 32'd0, '1, '1, 32'd0);                         sender_gap(idle_len());
    // size score exactly on the threshold, then just over it
    send_metrics(FS_ENERGY, FS_PHASE, FS_L1, 32'd0, 32'd0);         sender_gap(idle_len());
    send_metrics(FS_ENERGY, FS_PHASE, FS_L1, 32'd11, 32'd0);        sender_gap(idle_len());
    // just under and just over each full scale
    send_metrics(FS_ENERGY - 1, FS_PHASE - 1, FS_L1 - 1, FS_L2 - 1, FS_SHARE - 1);
    sender_gap(idle_len());
    send_metrics(FS_ENERGY + 1, FS_PHASE + 1, FS_L1 + 1, FS_L2 + 1, FS_SHARE + 1);
    sender_gap(idle_len());
    // big pool by misses on top of zero energy; full allowance repeated, all four cores each time
    send_metrics(32'd0, 32'd0, '1, '1, 32'd0);                      sender_gap(idle_len());
    repeat (3) begin
      send_metrics(32'd0, FS_PHASE, 32'd0, 32'd0, FS_SHARE);        sender_gap(idle_len());
    end
    // allowances of one to three cores, tiny allowances
    send_metrics(32'd54, 32'd0, 32'd0, 32'd0, 32'd0);               sender_gap(idle_len());
    send_metrics(FS_ENERGY, 32'd1, 32'd0, 32'd0, 32'd0);            sender_gap(idle_len());
    send_metrics(FS_ENERGY, 32'd0, 32'd0, 32'd0, 32'd1);            sender_gap(idle_len());
    send_metrics(32'd0, FS_PHASE / 2, 32'd0, 32'd0, 32'd0);         sender_gap(idle_len());
    send_metrics(32'd0, FS_PHASE, 32'd0, 32'd0, 32'd0);             sender_gap(idle_len());
    send_metrics(32'd0, 32'd0, FS_L1, FS_L2, FS_SHARE / 2);         sender_gap(idle_len());
    // alternating bit patterns
    send_metrics(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_metrics(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    send_metrics(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    drain_results();

    // random tasks in stretches, some of them with no sender gaps
    gaps_on = 1'b1;
    for (int unsigned i = 0; i < RANDOM_TASKS; i++) begin
      if (i % STRETCH_TASKS == 0) begin
        gaps_on = ($urandom_range(0, 3) != 0);
      end
      if (i == RANDOM_TASKS / 2) begin
        drain_results();
      end
      case ($urandom_range(0, 19))
        // idle task: no allowance at all
        0: begin
          e  = $urandom_range(FS_ENERGY, 32'hFFFF_FFFF);
          p  = 32'd0;
          l1 = metric_value(FS_L1);
          l2 = metric_value(FS_L2);
          s  = 32'd0;
        end
        // size score on or just above the threshold
        1: begin
          e  = $urandom_range(FS_ENERGY, 32'hFFFF_FFFF);
          p  = $urandom_range(FS_PHASE, 2 * FS_PHASE);
          l1 = $urandom_range(FS_L1, 2 * FS_L1);
          l2 = $urandom_range(0, 24);
          s  = metric_value(FS_SHARE);
        end
        default: begin
          e  = metric_value(FS_ENERGY);
          p  = metric_value(FS_PHASE);
          l1 = metric_value(FS_L1);
          l2 = metric_value(FS_L2);
          s  = metric_value(FS_SHARE);
        end
      endcase
      send_metrics(e, p, l1, l2, s);
      sender_gap(gaps_on ? idle_len() : 0);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
